// File: rtl/vmbb_pkg.sv
// ============================================================================
// vmbb_pkg
// Shared types, register indexes and saturating helpers of the balloon
// balancer.
// ============================================================================
package vmbb_pkg;

    localparam int KIB_W   = 32;
    localparam int DIDX_W  = 4;
    localparam int CFG_A_W = 3;

    localparam logic [CFG_A_W-1:0] CFG_LOADED_THRESHOLD = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_FREE_THRESHOLD   = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_TRANSFER_STEP    = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_HOST_GRANT       = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_HOST_RESERVE     = 3'd4;

    localparam logic [KIB_W-1:0] RST_LOADED_THRESHOLD = 32'd102400;
    localparam logic [KIB_W-1:0] RST_FREE_THRESHOLD   = 32'd153600;
    localparam logic [KIB_W-1:0] RST_TRANSFER_STEP    = 32'd51200;
    localparam logic [KIB_W-1:0] RST_HOST_GRANT       = 32'd102400;
    localparam logic [KIB_W-1:0] RST_HOST_RESERVE     = 32'd204800;

    typedef struct packed {
        logic [KIB_W-1:0] unused_kib;
        logic [KIB_W-1:0] available_kib;
        logic [KIB_W-1:0] host_free_kib;
        logic             last_domain;
    } item_beat_t;

    typedef struct packed {
        logic [DIDX_W-1:0] domain_index;
        logic [KIB_W-1:0]  new_size_kib;
        logic              last_command;
    } cmd_beat_t;

    typedef struct packed {
        logic [KIB_W-1:0] unused_kib;
        logic [KIB_W-1:0] available_kib;
    } store_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_MOST,
        ST_LEAST,
        ST_SWEEP,
        ST_FLUSH
    } state_t;

    function automatic logic [KIB_W-1:0] sat_sub(input logic [KIB_W-1:0] a,
                                                 input logic [KIB_W-1:0] b);
        logic [KIB_W-1:0] r;
        r = (a > b) ? (a - b) : '0;
        return r;
    endfunction

    function automatic logic [KIB_W-1:0] sat_add(input logic [KIB_W-1:0] a,
                                                 input logic [KIB_W-1:0] b);
        logic [KIB_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[KIB_W] ? '1 : s[KIB_W-1:0];
    endfunction

endpackage

// File: rtl/vm_memory_balloon_balancer_unit.sv
// ============================================================================
// vm_memory_balloon_balancer_unit
// Collects one statistics beat per guest domain and issues resize commands
// at the end of each round.
// ============================================================================
// Channels: item (valid/ready, item_beat_t) takes one beat per domain;
// cmd (valid/ready, cmd_beat_t) returns resize commands; cfg (valid/ready,
// index and data) writes the five thresholds and is always ready.
// An item without last_domain is written to the entry memory, while it has
// room, and the richest/neediest tracking is updated; item_ready stays high.
// The item with last_domain starts the end-of-round walk and item_ready
// drops until it ends: a plan state, a state each for the richest and
// neediest entry, then a sweep over every stored entry when the host is
// starved, and a flush state; stalls of the cmd receiver lengthen it.
// The walk is paced by the single read port of the entry memory; entries
// are written only while item_ready is high and read only while it is low,
// so no forwarding is needed.
// Commands pass through a pending slot so the final one of a round carries
// last_command; a stalled receiver holds the cmd register, and once the pending slot is full it halts the walk.
// Reset returns the thresholds to their defaults and empties the round;
// the entry memory needs no clearing.
// ============================================================================
module vm_memory_balloon_balancer_unit
    import vmbb_pkg::*;
#(
    parameter int MAX_DOMAINS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  item_beat_t         item,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output cmd_beat_t          cmd,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_A_W-1:0] cfg_index,
    input  logic [KIB_W-1:0]   cfg_data
);

    localparam int IDX_W = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
    localparam int CNT_W = $clog2(MAX_DOMAINS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DOMAINS);

    logic [KIB_W-1:0] loaded_thr_reg;
    logic [KIB_W-1:0] free_thr_reg;
    logic [KIB_W-1:0] step_reg;
    logic [KIB_W-1:0] grant_reg;
    logic [KIB_W-1:0] reserve_reg;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] sw_reg;
    logic [CNT_W-1:0] sw_next;
    logic [CNT_W-1:0] sw_plus;
    logic [IDX_W-1:0] most_reg;
    logic [IDX_W-1:0] least_reg;
    logic [KIB_W-1:0] most_val_reg;
    logic [KIB_W-1:0] least_val_reg;
    logic [KIB_W-1:0] host_free_reg;

    cmd_beat_t        pend_reg;
    logic             pend_valid_reg;
    cmd_beat_t        cmd_reg;
    logic             cmd_valid_reg;

    logic             accept;
    logic             store_en;
    logic [IDX_W-1:0] wr_idx;
    store_word_t      wr_word;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    store_word_t      rd_word;

    logic             starve;
    logic             rich;
    logic             host_ok;
    logic             sweep;
    logic             do_b;
    logic [KIB_W-1:0] b_amount;

    logic             out_free;
    logic             can_emit;
    logic             gen_req;
    logic             stall;
    logic             gen_fire;
    logic             flush_push;
    logic             push;
    logic [IDX_W-1:0] idx_sel;
    logic [IDX_W+DIDX_W-1:0] idx_wide;
    logic [KIB_W-1:0] size_sel;
    cmd_beat_t        gen_beat;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_thr_reg <= RST_LOADED_THRESHOLD;
            free_thr_reg   <= RST_FREE_THRESHOLD;
            step_reg       <= RST_TRANSFER_STEP;
            grant_reg      <= RST_HOST_GRANT;
            reserve_reg    <= RST_HOST_RESERVE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LOADED_THRESHOLD: loaded_thr_reg <= cfg_data;
                CFG_FREE_THRESHOLD:   free_thr_reg   <= cfg_data;
                CFG_TRANSFER_STEP:    step_reg       <= cfg_data;
                CFG_HOST_GRANT:       grant_reg      <= cfg_data;
                CFG_HOST_RESERVE:     reserve_reg    <= cfg_data;
                default:              ;
            endcase
        end
    end

    // ---------------------------------------------------------- entry store
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign store_en   = accept && (cnt_reg < CNT_MAX);
    assign wr_idx     = cnt_reg[IDX_W-1:0];
    assign wr_word    = '{unused_kib: item.unused_kib, available_kib: item.available_kib};

    vmbb_store #(
        .DEPTH (MAX_DOMAINS)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (wr_idx),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            most_reg  <= '0;
            least_reg <= '0;
        end
        else if (store_en)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == '0)
            begin
                most_reg  <= '0;
                least_reg <= '0;
            end
            else
            begin
                if (item.unused_kib > most_val_reg)
                begin
                    most_reg <= wr_idx;
                end
                if (item.unused_kib < least_val_reg)
                begin
                    least_reg <= wr_idx;
                end
            end
        end
        else if (state_reg == ST_FLUSH && state_next == ST_IDLE)
        begin
            cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            if (cnt_reg == '0 || item.unused_kib > most_val_reg)
            begin
                most_val_reg <= item.unused_kib;
            end
            if (cnt_reg == '0 || item.unused_kib < least_val_reg)
            begin
                least_val_reg <= item.unused_kib;
            end
        end
        if (accept)
        begin
            host_free_reg <= item.host_free_kib;
        end
    end

    // ------------------------------------------------------------- decisions
    assign starve   = (least_val_reg <= loaded_thr_reg);
    assign rich     = (most_val_reg >= free_thr_reg);
    assign host_ok  = (host_free_reg > reserve_reg);
    assign sweep    = (host_free_reg <= loaded_thr_reg);
    assign do_b     = starve && (rich || host_ok);
    assign b_amount = rich ? step_reg : grant_reg;

    // ------------------------------------------------------------ sequencer
    assign out_free = !cmd_valid_reg || cmd_ready;
    assign can_emit = !pend_valid_reg || out_free;
    assign stall    = gen_req && !can_emit;
    assign gen_fire = gen_req && can_emit;
    assign push     = (gen_fire && pend_valid_reg) || flush_push;
    assign sw_plus  = sw_reg + 1'b1;
    assign idx_wide = {{DIDX_W{1'b0}}, idx_sel};
    assign gen_beat = '{domain_index: idx_wide[DIDX_W-1:0],
                        new_size_kib: size_sel,
                        last_command: 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sw_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sw_reg    <= sw_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sw_next    = sw_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        gen_req    = 1'b0;
        idx_sel    = '0;
        size_sel   = '0;
        flush_push = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.last_domain)
                begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                rd_en      = 1'b1;
                rd_addr    = most_reg;
                state_next = ST_MOST;
            end
            ST_MOST:
            begin
                gen_req  = rich;
                idx_sel  = most_reg;
                size_sel = sat_sub(rd_word.available_kib, step_reg);
                if (!stall)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = least_reg;
                    state_next = ST_LEAST;
                end
            end
            ST_LEAST:
            begin
                gen_req  = do_b;
                idx_sel  = least_reg;
                size_sel = sat_add(rd_word.available_kib, b_amount);
                if (!stall)
                begin
                    if (sweep)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        sw_next    = '0;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_SWEEP:
            begin
                gen_req  = (rd_word.unused_kib >= free_thr_reg);
                idx_sel  = sw_reg[IDX_W-1:0];
                size_sel = sat_sub(rd_word.available_kib, step_reg);
                if (!stall)
                begin
                    if (sw_plus < cnt_reg)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = sw_plus[IDX_W-1:0];
                        sw_next = sw_plus;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    flush_push = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // --------------------------------------------------- pending and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            cmd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (gen_fire)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush_push)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (cmd_ready)
            begin
                cmd_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_fire)
        begin
            pend_reg <= gen_beat;
        end
        if (push)
        begin
            cmd_reg <= '{domain_index: pend_reg.domain_index,
                         new_size_kib: pend_reg.new_size_kib,
                         last_command: flush_push};
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    // ------------------------------------------------------------ assertions
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !pend_valid_reg)
        else $error("pending command left over while accepting items");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("entry count beyond memory depth");

    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.last_domain) |=> !item_ready)
        else $error("item accepted during end-of-round walk");

    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (sw_reg < cnt_reg))
        else $error("sweep index past stored entries");

endmodule

// File: rtl/vmbb_store.sv
// ============================================================================
// vmbb_store
// Per-domain entry memory: one write port, one read port, registered read.
// ============================================================================
module vmbb_store
    import vmbb_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  store_word_t       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output store_word_t       rd_data
);

    store_word_t mem [DEPTH];
    store_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sim/vm_memory_balloon_balancer_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// vm_memory_balloon_balancer_unit_tb
// Feeds rounds of per-domain memory statistics into the balancer and checks
// every resize command against a balancing model kept in the bench, or against
// expected commands written into the table. A short table of hand-picked rounds
// runs first. Random rounds follow under six threshold settings, including
// all-zero and all-ones. Both channels idle and stall at random.
// ============================================================================
module vm_memory_balloon_balancer_unit_tb;
    import vmbb_pkg::*;

    localparam int DOMAIN_SLOTS   = 16;
    localparam int ITEM_GOAL      = 330;
    localparam int PHASES         = 6;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;
    localparam int TABLE_ROWS     = 16;

    localparam cmd_beat_t NO_CMD = '0;

    typedef struct {
        item_beat_t beat;
        bit         typed;
        int         n_exp;
        cmd_beat_t  exp0;
        cmd_beat_t  exp1;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    item_beat_t         item;
    logic               cmd_valid;
    logic               cmd_ready = 1'b0;
    cmd_beat_t          cmd;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_A_W-1:0] cfg_index;
    logic [KIB_W-1:0]   cfg_data;

    logic [KIB_W-1:0] loaded_lim;
    logic [KIB_W-1:0] free_lim;
    logic [KIB_W-1:0] step_kib;
    logic [KIB_W-1:0] grant_kib;
    logic [KIB_W-1:0] reserve_kib;
    logic [KIB_W-1:0] unused_mem [DOMAIN_SLOTS];
    logic [KIB_W-1:0] avail_mem  [DOMAIN_SLOTS];
    int unsigned      stored_cnt;
    int unsigned      rich_idx;
    int unsigned      poor_idx;

    cmd_beat_t resize_plan [$];
    cmd_beat_t resize_due  [$];
    cmd_beat_t due_cmd;
    stim_row_t stim_tab [TABLE_ROWS];

    int unsigned items_sent      = 0;
    int unsigned rounds_done     = 0;
    int unsigned cmds_seen       = 0;
    int unsigned cfg_writes      = 0;
    int unsigned overflow_rounds = 0;
    int unsigned err_cnt         = 0;
    int unsigned burst_left      = 0;
    int unsigned quiet_cycles    = 0;
    logic [31:0] ready_pat       = '1;
    logic [4:0]  ready_ptr       = '0;

    vm_memory_balloon_balancer_unit #(
        .MAX_DOMAINS (DOMAIN_SLOTS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [KIB_W-1:0] trim_kib(input logic [KIB_W-1:0] size,
                                                  input logic [KIB_W-1:0] delta);
        return (size > delta) ? size - delta : '0;
    endfunction

    function automatic logic [KIB_W-1:0] grow_kib(input logic [KIB_W-1:0] size,
                                                  input logic [KIB_W-1:0] delta);
        return (size > ~delta) ? '1 : size + delta;
    endfunction

    function automatic logic [KIB_W-1:0] near(input logic [KIB_W-1:0] v);
        logic [KIB_W-1:0] d;
        d = $urandom_range(0, 2);
        return v + d - 32'd1;
    endfunction

    function automatic logic [KIB_W-1:0] pick_unused();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return near(loaded_lim);
            4, 5:    return near(free_lim);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KIB_W-1:0] pick_avail();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return near(step_kib);
            3:       return near(~grant_kib);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KIB_W-1:0] pick_host();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return near(loaded_lim);
            3:       return near(reserve_kib);
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_row_t stim_row(input logic [KIB_W-1:0] u,
                                           input logic [KIB_W-1:0] a,
                                           input logic [KIB_W-1:0] h,
                                           input logic             l,
                                           input bit               t,
                                           input int               n,
                                           input cmd_beat_t        e0,
                                           input cmd_beat_t        e1);
        stim_row_t r;
        r.beat.unused_kib    = u;
        r.beat.available_kib = a;
        r.beat.host_free_kib = h;
        r.beat.last_domain   = l;
        r.typed = t;
        r.n_exp = n;
        r.exp0  = e0;
        r.exp1  = e1;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    task automatic add_resize(input int unsigned idx, input logic [KIB_W-1:0] size);
        cmd_beat_t c;
        c.domain_index = idx[DIDX_W-1:0];
        c.new_size_kib = size;
        c.last_command = 1'b0;
        resize_plan.push_back(c);
    endtask

    task automatic balance_step(input item_beat_t b);
        int unsigned slot;
        cmd_beat_t   tail;
        resize_plan.delete();
        if (stored_cnt < DOMAIN_SLOTS)
        begin
            slot = stored_cnt;
            unused_mem[slot] = b.unused_kib;
            avail_mem[slot]  = b.available_kib;
            if (slot == 0)
            begin
                rich_idx = 0;
                poor_idx = 0;
            end
            else
            begin
                if (b.unused_kib > unused_mem[rich_idx])
                    rich_idx = slot;
                if (b.unused_kib < unused_mem[poor_idx])
                    poor_idx = slot;
            end
            stored_cnt = slot + 1;
        end
        if (b.last_domain)
        begin
            if (unused_mem[poor_idx] <= loaded_lim)
            begin
                if (unused_mem[rich_idx] >= free_lim)
                begin
                    add_resize(rich_idx, trim_kib(avail_mem[rich_idx], step_kib));
                    add_resize(poor_idx, grow_kib(avail_mem[poor_idx], step_kib));
                end
                else if (b.host_free_kib > reserve_kib)
                    add_resize(poor_idx, grow_kib(avail_mem[poor_idx], grant_kib));
            end
            else if (unused_mem[rich_idx] >= free_lim)
                add_resize(rich_idx, trim_kib(avail_mem[rich_idx], step_kib));
            if (b.host_free_kib <= loaded_lim)
            begin
                for (slot = 0; slot < stored_cnt; slot++)
                begin
                    if (unused_mem[slot] >= free_lim)
                        add_resize(slot, trim_kib(avail_mem[slot], step_kib));
                end
            end
            if (resize_plan.size() > 0)
            begin
                tail = resize_plan.pop_back();
                tail.last_command = 1'b1;
                resize_plan.push_back(tail);
            end
            stored_cnt = 0;
            rounds_done++;
        end
    endtask

    // hold valid until accepted, then queue what the round produces
    task automatic push_item(input stim_row_t r);
        item_valid = 1'b1;
        item       = r.beat;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        balance_step(r.beat);
        if (r.typed)
        begin
            if (r.n_exp > 0)
                resize_due.push_back(r.exp0);
            if (r.n_exp > 1)
                resize_due.push_back(r.exp1);
        end
        else
        begin
            foreach (resize_plan[k])
                resize_due.push_back(resize_plan[k]);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic rest(input int unsigned cycles);
        item_valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic pace();
        if (burst_left == 0)
        begin
            rest($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
        end
        else
            burst_left--;
    endtask

    task automatic drain();
        item_valid = 1'b0;
        while (resize_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [KIB_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LOADED_THRESHOLD: loaded_lim  = data;
            CFG_FREE_THRESHOLD:   free_lim    = data;
            CFG_TRANSFER_STEP:    step_kib    = data;
            CFG_HOST_GRANT:       grant_kib   = data;
            CFG_HOST_RESERVE:     reserve_kib = data;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_setting(input int phase);
        logic [KIB_W-1:0] v0, v1, v2, v3, v4;
        case (phase)
            1:
            begin
                v0 = '0; v1 = '0; v2 = '0; v3 = '0; v4 = '0;
            end
            2:
            begin
                v0 = '1; v1 = '1; v2 = '1; v3 = '1; v4 = '1;
            end
            3:
            begin
                v0 = $urandom_range(0, 1 << 20);
                v1 = v0 + $urandom_range(0, 1 << 20);
                v2 = $urandom_range(0, 1 << 19);
                v3 = $urandom_range(0, 1 << 20);
                v4 = $urandom_range(0, 1 << 21);
            end
            4:
            begin
                v0 = $urandom; v1 = $urandom; v2 = $urandom; v3 = $urandom; v4 = $urandom;
            end
            default:
            begin
                v0 = RST_LOADED_THRESHOLD;
                v1 = RST_FREE_THRESHOLD;
                v2 = RST_TRANSFER_STEP;
                v3 = RST_HOST_GRANT;
                v4 = RST_HOST_RESERVE;
            end
        endcase
        write_reg(CFG_LOADED_THRESHOLD, v0);
        write_reg(CFG_FREE_THRESHOLD, v1);
        write_reg(CFG_TRANSFER_STEP, v2);
        write_reg(CFG_HOST_GRANT, v3);
        write_reg(CFG_HOST_RESERVE, v4);
    endtask

    task automatic random_round();
        int unsigned len;
        int unsigned k;
        stim_row_t   r;
        case ($urandom_range(0, 19))
            0:       len = $urandom_range(DOMAIN_SLOTS + 1, DOMAIN_SLOTS + 2);
            1, 2:    len = DOMAIN_SLOTS;
            default: len = $urandom_range(1, 6);
        endcase
        if (len > DOMAIN_SLOTS)
            overflow_rounds++;
        for (k = 1; k <= len; k++)
        begin
            r = stim_row(pick_unused(), pick_avail(), pick_host(),
                         (k == len) || ($urandom_range(0, 29) == 0), 1'b0, 0, NO_CMD, NO_CMD);
            push_item(r);
            pace();
            if (r.beat.last_domain)
                break;
        end
    endtask

    always @(negedge clk)
    begin
        if (ready_ptr == 0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pat = '1;
                1:       ready_pat = $urandom;
                2:       ready_pat = $urandom | $urandom;
                default: ready_pat = $urandom & $urandom;
            endcase
        end
        cmd_ready <= ready_pat[ready_ptr];
        ready_ptr <= ready_ptr + 5'd1;
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && cmd_ready)
        begin
            cmds_seen++;
            if (resize_due.size() == 0)
                flag_error($sformatf("unexpected command: idx %0d size %0d last %0b",
                                     cmd.domain_index, cmd.new_size_kib, cmd.last_command));
            else
            begin
                due_cmd = resize_due.pop_front();
                if (cmd.domain_index !== due_cmd.domain_index ||
                    cmd.new_size_kib !== due_cmd.new_size_kib ||
                    cmd.last_command !== due_cmd.last_command)
                    flag_error($sformatf({"command %0d mismatch: expected idx %0d size %0d ",
                                          "last %0b, got idx %0d size %0d last %0b"},
                                         cmds_seen, due_cmd.domain_index,
                                         due_cmd.new_size_kib, due_cmd.last_command,
                                         cmd.domain_index, cmd.new_size_kib,
                                         cmd.last_command));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (cmd_valid && cmd_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (rst_n)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles, %0d commands outstanding",
                         quiet_cycles, resize_due.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        loaded_lim  = RST_LOADED_THRESHOLD;
        free_lim    = RST_FREE_THRESHOLD;
        step_kib    = RST_TRANSFER_STEP;
        grant_kib   = RST_HOST_GRANT;
        reserve_kib = RST_HOST_RESERVE;
        stored_cnt  = 0;
        rich_idx    = 0;
        poor_idx    = 0;

        stim_tab[0]  = stim_row(32'd0, 32'd1000, '1, 1'b1, 1'b1, 1,
                                {4'd0, 32'd103400, 1'b1}, NO_CMD);
        stim_tab[1]  = stim_row('1, 32'd0, 32'd0, 1'b1, 1'b1, 2,
                                {4'd0, 32'd0, 1'b0}, {4'd0, 32'd0, 1'b1});
        stim_tab[2]  = stim_row(32'd0, '1, '1, 1'b1, 1'b1, 1,
                                {4'd0, 32'hFFFF_FFFF, 1'b1}, NO_CMD);
        stim_tab[3]  = stim_row(32'd200000, 32'd500000, 32'd0, 1'b0, 1'b1, 0, NO_CMD, NO_CMD);
        stim_tab[4]  = stim_row(32'd50000, 32'hFFFF_FFF0, 32'd300000, 1'b1, 1'b1, 2,
                                {4'd0, 32'd448800, 1'b0}, {4'd1, 32'hFFFF_FFFF, 1'b1});
        stim_tab[5]  = stim_row(32'd120000, 32'd5, 32'd300000, 1'b1, 1'b1, 0, NO_CMD, NO_CMD);
        stim_tab[6]  = stim_row(32'd0, 32'd7, 32'd204800, 1'b1, 1'b1, 0, NO_CMD, NO_CMD);
        stim_tab[7]  = stim_row(32'd100000, 32'd1, 32'd0, 1'b0, 1'b0, 0, NO_CMD, NO_CMD);
        stim_tab[8]  = stim_row(32'd100000, 32'd2, 32'd0, 1'b0, 1'b0, 0, NO_CMD, NO_CMD);
        stim_tab[9]  = stim_row(32'd100000, 32'd3, 32'd300000, 1'b1, 1'b0, 0, NO_CMD, NO_CMD);
        stim_tab[10] = stim_row(32'd400000, 32'd60000, 32'd0, 1'b0, 1'b0, 0, NO_CMD, NO_CMD);
        stim_tab[11] = stim_row(32'd10, 32'd70000, 32'd0, 1'b0, 1'b0, 0, NO_CMD, NO_CMD);
        stim_tab[12] = stim_row(32'd153600, 32'd40000, 32'd0, 1'b0, 1'b0, 0, NO_CMD, NO_CMD);
        stim_tab[13] = stim_row(32'd90000, 32'd80000, 32'd102400, 1'b1, 1'b0, 0,
                                NO_CMD, NO_CMD);
        stim_tab[14] = stim_row(32'd153600, 32'd51200, 32'd0, 1'b0, 1'b0, 0, NO_CMD, NO_CMD);
        stim_tab[15] = stim_row(32'd102400, 32'd0, '1, 1'b1, 1'b0, 0, NO_CMD, NO_CMD);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < TABLE_ROWS; r++)
        begin
            push_item(stim_tab[r]);
            pace();
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                load_setting(p);
            end
            while (items_sent < TABLE_ROWS + (ITEM_GOAL - TABLE_ROWS) * (p + 1) / PHASES)
            begin
                random_round();
                if ($urandom_range(0, 11) == 0)
                    drain();
            end
        end

        drain();
        if (resize_due.size() != 0)
            flag_error($sformatf("%0d commands never arrived", resize_due.size()));

        $display("run: %0d domain beats in %0d rounds (%0d past capacity), %0d commands",
                 items_sent, rounds_done, overflow_rounds, cmds_seen);
        $display("     %0d register writes over %0d threshold settings, %0d errors",
                 cfg_writes, PHASES, err_cnt);
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/vmbb_pkg.sv
rtl/vmbb_store.sv
rtl/vm_memory_balloon_balancer_unit.sv
sim/vm_memory_balloon_balancer_unit_tb.sv
